FILE: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Default sizes
  localparam int unsigned DEF_CAPACITY       = 64;
  localparam int unsigned DEF_ELEMENT_WIDTH  = 16;
  localparam int unsigned DEF_PRIORITY_WIDTH = 16;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT          = 3'd0,
    CMD_REMOVE_HEAD     = 3'd1,
    CMD_REMOVE_ELEMENT  = 3'd2,
    CMD_CHANGE_PRIORITY = 3'd3,
    CMD_CONTAINS        = 3'd4,
    CMD_FIRST           = 3'd5,
    CMD_NEXT            = 3'd6,
    CMD_CLEAR           = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // What one cell loads on an update cycle
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_PREV,
    ACT_NEXT
  } cell_act_e;

  // Update applied to the whole chain
  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DROP_HEAD,
    MODE_DROP_ELEMENT,
    MODE_DROP_MATCH
  } chain_mode_e;

  // Position information the chain hands to each cell
  typedef struct packed {
    logic occupied;
    logic at_cursor;
  } cell_pos_t;

  // Compare results registered in each cell
  typedef struct packed {
    logic ge;
    logic match_el;
    logic match_both;
    logic at_cursor;
  } cell_flags_t;

  // Summary the chain returns to the control
  typedef struct packed {
    logic any_el;
    logic any_both;
  } chain_status_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cmd_if.sv
`default_nettype none

interface spq_cmd_if #(
  parameter int unsigned ELEMENT_WIDTH  = spq_pkg::DEF_ELEMENT_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
);
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [ELEMENT_WIDTH-1:0]  element;
  logic [PRIORITY_WIDTH-1:0] priority_req;
  logic [PRIORITY_WIDTH-1:0] match_priority;

  modport source (
    output valid, command, element, priority_req, match_priority,
    input  ready
  );

  modport sink (
    input  valid, command, element, priority_req, match_priority,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/spq_rsp_if.sv
`default_nettype none

interface spq_rsp_if #(
  parameter int unsigned ELEMENT_WIDTH  = spq_pkg::DEF_ELEMENT_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH,
  parameter int unsigned COUNT_WIDTH    = $clog2(spq_pkg::DEF_CAPACITY + 1)
);
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      found;
  logic                      item_valid;
  logic [ELEMENT_WIDTH-1:0]  item_element;
  logic [PRIORITY_WIDTH-1:0] item_priority;
  logic [COUNT_WIDTH-1:0]    entry_count;
  logic                      head_valid;
  logic [ELEMENT_WIDTH-1:0]  head_element;
  logic [PRIORITY_WIDTH-1:0] head_priority;

  modport source (
    output valid, status, found, item_valid, item_element, item_priority,
           entry_count, head_valid, head_element, head_priority,
    input  ready
  );

  modport sink (
    input  valid, status, found, item_valid, item_element, item_priority,
           entry_count, head_valid, head_element, head_priority,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/sorted_priority_queue_core.sv
// A command moves from idle to a compare state and then an update state; the result is registered.
// No new command is taken until the current one is done and the result register is empty or being taken.
// In the compare cycle every cell registers its flags, and in the update cycle
// the row shifts by at most one position; change priority runs both again.
// Reset clears the entry count, the iteration cursor and the result register;
// entry storage is not cleared.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY       = spq_pkg::DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH  = spq_pkg::DEF_ELEMENT_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spq_cmd_if.sink     cmd_i,
  spq_rsp_if.source   rsp_o
);
  import spq_pkg::*;

  localparam int unsigned COUNT_WIDTH = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_WIDTH   = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  state_e                    state_q, state_d;
  logic                      second_q, second_d;
  cmd_e                      cmd_q, cmd_d;
  logic [ELEMENT_WIDTH-1:0]  el_q, el_d;
  logic [PRIORITY_WIDTH-1:0] pr_q, pr_d;
  logic [PRIORITY_WIDTH-1:0] op_q, op_d;
  logic [COUNT_WIDTH-1:0]    count_q, count_d;
  logic [IDX_WIDTH-1:0]      cursor_q, cursor_d;
  logic                      cursor_valid_q, cursor_valid_d;

  logic                      rsp_valid_q, rsp_valid_d;
  status_e                   rsp_status_q, rsp_status_d;
  logic                      rsp_found_q, rsp_found_d;
  logic                      rsp_item_valid_q, rsp_item_valid_d;
  logic [ELEMENT_WIDTH-1:0]  rsp_item_el_q, rsp_item_el_d;
  logic [PRIORITY_WIDTH-1:0] rsp_item_pr_q, rsp_item_pr_d;
  logic [COUNT_WIDTH-1:0]    rsp_count_q, rsp_count_d;
  logic                      rsp_head_valid_q, rsp_head_valid_d;
  logic [ELEMENT_WIDTH-1:0]  rsp_head_el_q, rsp_head_el_d;
  logic [PRIORITY_WIDTH-1:0] rsp_head_pr_q, rsp_head_pr_d;

  logic                      cmd_transfer;
  logic                      full;
  logic [COUNT_WIDTH-1:0]    cursor_target;
  logic                      flags_en;
  chain_mode_e               mode;
  chain_status_t             chain_status;
  logic [ELEMENT_WIDTH-1:0]  head_el;
  logic [PRIORITY_WIDTH-1:0] head_pr;
  logic [ELEMENT_WIDTH-1:0]  item_el;
  logic [PRIORITY_WIDTH-1:0] item_pr;
  logic                      finish;
  status_e                   status_c;
  logic                      found_c;
  logic                      item_valid_c;

  assign cmd_i.ready  = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign cmd_transfer = cmd_i.valid && cmd_i.ready;
  assign full         = count_q == COUNT_WIDTH'(CAPACITY);

  // First points at the head, next at the entry after the cursor
  assign cursor_target = (cmd_q == CMD_FIRST) ? '0
                       : COUNT_WIDTH'(cursor_q) + COUNT_WIDTH'(1);

  spq_chain #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_chain (
    .clk_i     (clk_i),
    .flags_en_i(flags_en),
    .mode_i    (mode),
    .count_i   (count_q),
    .cursor_i  (cursor_target),
    .el_i      (el_q),
    .pr_i      (pr_q),
    .op_i      (op_q),
    .status_o  (chain_status),
    .head_el_o (head_el),
    .head_pr_o (head_pr),
    .item_el_o (item_el),
    .item_pr_o (item_pr)
  );

  // Sequence each command through compare and update
  always_comb begin
    state_d          = state_q;
    second_d         = second_q;
    cmd_d            = cmd_q;
    el_d             = el_q;
    pr_d             = pr_q;
    op_d             = op_q;
    count_d          = count_q;
    cursor_d         = cursor_q;
    cursor_valid_d   = cursor_valid_q;
    rsp_valid_d      = rsp_valid_q && !rsp_o.ready;
    rsp_status_d     = rsp_status_q;
    rsp_found_d      = rsp_found_q;
    rsp_item_valid_d = rsp_item_valid_q;
    rsp_item_el_d    = rsp_item_el_q;
    rsp_item_pr_d    = rsp_item_pr_q;
    rsp_count_d      = rsp_count_q;
    rsp_head_valid_d = rsp_head_valid_q;
    rsp_head_el_d    = rsp_head_el_q;
    rsp_head_pr_d    = rsp_head_pr_q;
    flags_en         = 1'b0;
    mode             = MODE_HOLD;
    finish           = 1'b0;
    status_c         = STATUS_OK;
    found_c          = 1'b0;
    item_valid_c     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_transfer) begin
          cmd_d    = cmd_e'(cmd_i.command);
          el_d     = cmd_i.element;
          pr_d     = cmd_i.priority_req;
          op_d     = cmd_i.match_priority;
          second_d = 1'b0;
          state_d  = S_EVAL;
        end
      end

      S_EVAL: begin
        flags_en = 1'b1;
        state_d  = S_APPLY;
      end

      S_APPLY: begin
        finish = 1'b1;
        unique case (cmd_q)
          CMD_INSERT: begin
            cursor_valid_d = 1'b0;
            if (full) begin
              status_c = STATUS_FULL;
            end else begin
              mode    = MODE_INSERT;
              count_d = count_q + COUNT_WIDTH'(1);
            end
          end
          CMD_REMOVE_HEAD: begin
            cursor_valid_d = 1'b0;
            if (count_q != '0) begin
              mode    = MODE_DROP_HEAD;
              count_d = count_q - COUNT_WIDTH'(1);
            end
          end
          CMD_REMOVE_ELEMENT: begin
            cursor_valid_d = 1'b0;
            if (chain_status.any_el) begin
              mode    = MODE_DROP_ELEMENT;
              count_d = count_q - COUNT_WIDTH'(1);
            end else begin
              status_c = STATUS_NOT_FOUND;
            end
          end
          CMD_CHANGE_PRIORITY: begin
            cursor_valid_d = 1'b0;
            if (second_q) begin
              // drop the old entry, still the first match after the insert
              mode    = MODE_DROP_MATCH;
              count_d = count_q - COUNT_WIDTH'(1);
            end else if (!chain_status.any_both) begin
              status_c = STATUS_NOT_FOUND;
            end else if (full) begin
              status_c = STATUS_FULL;
            end else begin
              mode     = MODE_INSERT;
              count_d  = count_q + COUNT_WIDTH'(1);
              finish   = 1'b0;
              second_d = 1'b1;
              state_d  = S_EVAL;
            end
          end
          CMD_CONTAINS: begin
            found_c = chain_status.any_el;
          end
          CMD_FIRST, CMD_NEXT: begin
            if ((cmd_q == CMD_FIRST || cursor_valid_q) && cursor_target < count_q) begin
              cursor_d       = cursor_target[IDX_WIDTH-1:0];
              cursor_valid_d = 1'b1;
              item_valid_c   = 1'b1;
            end else begin
              cursor_valid_d = 1'b0;
            end
          end
          CMD_CLEAR: begin
            cursor_valid_d = 1'b0;
            count_d        = '0;
          end
          default: begin
            cursor_valid_d = 1'b0;
          end
        endcase

        // Load the result register
        if (finish) begin
          rsp_valid_d      = 1'b1;
          rsp_status_d     = status_c;
          rsp_found_d      = found_c;
          rsp_item_valid_d = item_valid_c;
          rsp_item_el_d    = item_valid_c ? item_el : '0;
          rsp_item_pr_d    = item_valid_c ? item_pr : '0;
          rsp_count_d      = count_d;
          rsp_head_valid_d = count_d != '0;
          rsp_head_el_d    = (count_d != '0) ? head_el : '0;
          rsp_head_pr_d    = (count_d != '0) ? head_pr : '0;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      second_q         <= 1'b0;
      cmd_q            <= CMD_INSERT;
      el_q             <= '0;
      pr_q             <= '0;
      op_q             <= '0;
      count_q          <= '0;
      cursor_q         <= '0;
      cursor_valid_q   <= 1'b0;
      rsp_valid_q      <= 1'b0;
      rsp_status_q     <= STATUS_OK;
      rsp_found_q      <= 1'b0;
      rsp_item_valid_q <= 1'b0;
      rsp_item_el_q    <= '0;
      rsp_item_pr_q    <= '0;
      rsp_count_q      <= '0;
      rsp_head_valid_q <= 1'b0;
      rsp_head_el_q    <= '0;
      rsp_head_pr_q    <= '0;
    end else begin
      state_q          <= state_d;
      second_q         <= second_d;
      cmd_q            <= cmd_d;
      el_q             <= el_d;
      pr_q             <= pr_d;
      op_q             <= op_d;
      count_q          <= count_d;
      cursor_q         <= cursor_d;
      cursor_valid_q   <= cursor_valid_d;
      rsp_valid_q      <= rsp_valid_d;
      rsp_status_q     <= rsp_status_d;
      rsp_found_q      <= rsp_found_d;
      rsp_item_valid_q <= rsp_item_valid_d;
      rsp_item_el_q    <= rsp_item_el_d;
      rsp_item_pr_q    <= rsp_item_pr_d;
      rsp_count_q      <= rsp_count_d;
      rsp_head_valid_q <= rsp_head_valid_d;
      rsp_head_el_q    <= rsp_head_el_d;
      rsp_head_pr_q    <= rsp_head_pr_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.found         = rsp_found_q;
  assign rsp_o.item_valid    = rsp_item_valid_q;
  assign rsp_o.item_element  = rsp_item_el_q;
  assign rsp_o.item_priority = rsp_item_pr_q;
  assign rsp_o.entry_count   = rsp_count_q;
  assign rsp_o.head_valid    = rsp_head_valid_q;
  assign rsp_o.head_element  = rsp_head_el_q;
  assign rsp_o.head_priority = rsp_head_pr_q;

endmodule

`default_nettype wire

FILE: rtl/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int unsigned ELEMENT_WIDTH  = spq_pkg::DEF_ELEMENT_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      flags_en_i,
  input  wire spq_pkg::cell_pos_t        pos_i,
  input  wire spq_pkg::cell_act_e        act_i,
  input  wire logic [ELEMENT_WIDTH-1:0]  el_i,
  input  wire logic [PRIORITY_WIDTH-1:0] pr_i,
  input  wire logic [PRIORITY_WIDTH-1:0] op_i,
  input  wire logic [ELEMENT_WIDTH-1:0]  prev_el_i,
  input  wire logic [PRIORITY_WIDTH-1:0] prev_pr_i,
  input  wire logic [ELEMENT_WIDTH-1:0]  next_el_i,
  input  wire logic [PRIORITY_WIDTH-1:0] next_pr_i,
  output logic [ELEMENT_WIDTH-1:0]       el_o,
  output logic [PRIORITY_WIDTH-1:0]      pr_o,
  output spq_pkg::cell_flags_t           flags_o
);
  import spq_pkg::*;

  logic [ELEMENT_WIDTH-1:0]  el_q, el_d;
  logic [PRIORITY_WIDTH-1:0] pr_q, pr_d;
  cell_flags_t               flags_q, flags_d;

  // Compare the stored entry against the broadcast operands
  always_comb begin
    flags_d.ge         = pos_i.occupied && (pr_q >= pr_i);
    flags_d.match_el   = pos_i.occupied && (el_q == el_i);
    flags_d.match_both = pos_i.occupied && (el_q == el_i) && (pr_q == op_i);
    flags_d.at_cursor  = pos_i.at_cursor;
  end

  // Select the next entry: hold, take the new one, or shift from a neighbor
  always_comb begin
    case (act_i)
      ACT_LOAD: begin
        el_d = el_i;
        pr_d = pr_i;
      end
      ACT_PREV: begin
        el_d = prev_el_i;
        pr_d = prev_pr_i;
      end
      ACT_NEXT: begin
        el_d = next_el_i;
        pr_d = next_pr_i;
      end
      default: begin
        el_d = el_q;
        pr_d = pr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    el_q <= el_d;
    pr_q <= pr_d;
    if (flags_en_i) begin
      flags_q <= flags_d;
    end
  end

  assign el_o    = el_q;
  assign pr_o    = pr_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

FILE: rtl/spq_chain.sv
`default_nettype none

module spq_chain #(
  parameter int unsigned CAPACITY       = spq_pkg::DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH  = spq_pkg::DEF_ELEMENT_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH,
  parameter int unsigned COUNT_WIDTH    = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      flags_en_i,
  input  wire spq_pkg::chain_mode_e      mode_i,
  input  wire logic [COUNT_WIDTH-1:0]    count_i,
  input  wire logic [COUNT_WIDTH-1:0]    cursor_i,
  input  wire logic [ELEMENT_WIDTH-1:0]  el_i,
  input  wire logic [PRIORITY_WIDTH-1:0] pr_i,
  input  wire logic [PRIORITY_WIDTH-1:0] op_i,
  output spq_pkg::chain_status_t         status_o,
  output logic [ELEMENT_WIDTH-1:0]       head_el_o,
  output logic [PRIORITY_WIDTH-1:0]      head_pr_o,
  output logic [ELEMENT_WIDTH-1:0]       item_el_o,
  output logic [PRIORITY_WIDTH-1:0]      item_pr_o
);
  import spq_pkg::*;

  logic [ELEMENT_WIDTH-1:0]  cell_el [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_pr [CAPACITY];
  cell_flags_t               cell_flags [CAPACITY];
  cell_pos_t                 cell_pos [CAPACITY];
  cell_act_e                 cell_act [CAPACITY];

  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] ge_prev_vec;
  logic [CAPACITY-1:0] el_vec;
  logic [CAPACITY-1:0] both_vec;
  logic [CAPACITY-1:0] drop_vec;
  logic [CAPACITY-1:0] lowest_vec;
  logic [CAPACITY-1:0] after_vec;

  // Position of each cell relative to the fill level and the cursor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_pos[i].occupied  = COUNT_WIDTH'(i) < count_i;
      cell_pos[i].at_cursor = COUNT_WIDTH'(i) == cursor_i;
    end
  end

  // Gather registered flags into vectors
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_vec[i]   = cell_flags[i].ge;
      el_vec[i]   = cell_flags[i].match_el;
      both_vec[i] = cell_flags[i].match_both;
    end
  end

  // Cell zero always sees a higher neighbor that outranks the new entry
  assign ge_prev_vec = {ge_vec[CAPACITY-2:0], 1'b1};

  // Mark every cell at or after the first match, or every cell when dropping the head
  assign drop_vec   = (mode_i == MODE_DROP_MATCH) ? both_vec : el_vec;
  assign lowest_vec = drop_vec & (~drop_vec + CAPACITY'(1));
  assign after_vec  = (mode_i == MODE_DROP_HEAD) ? '1 : ~(lowest_vec - CAPACITY'(1));

  // Per-cell update command
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      case (mode_i)
        MODE_INSERT: begin
          if (ge_vec[i]) begin
            cell_act[i] = ACT_HOLD;
          end else if (ge_prev_vec[i]) begin
            cell_act[i] = ACT_LOAD;
          end else begin
            cell_act[i] = ACT_PREV;
          end
        end
        MODE_DROP_HEAD, MODE_DROP_ELEMENT, MODE_DROP_MATCH: begin
          cell_act[i] = after_vec[i] ? ACT_NEXT : ACT_HOLD;
        end
        default: begin
          cell_act[i] = ACT_HOLD;
        end
      endcase
    end
  end

  // Row of cells, each wired to its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int unsigned PREV = (g == 0) ? 0 : g - 1;
    localparam int unsigned NEXT = (g == CAPACITY - 1) ? g : g + 1;

    spq_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .flags_en_i(flags_en_i),
      .pos_i     (cell_pos[g]),
      .act_i     (cell_act[g]),
      .el_i      (el_i),
      .pr_i      (pr_i),
      .op_i      (op_i),
      .prev_el_i (cell_el[PREV]),
      .prev_pr_i (cell_pr[PREV]),
      .next_el_i (cell_el[NEXT]),
      .next_pr_i (cell_pr[NEXT]),
      .el_o      (cell_el[g]),
      .pr_o      (cell_pr[g]),
      .flags_o   (cell_flags[g])
    );
  end

  assign status_o.any_el   = |el_vec;
  assign status_o.any_both = |both_vec;

  // Head entry as it stands after this update
  always_comb begin
    case (mode_i)
      MODE_INSERT: begin
        head_el_o = ge_vec[0] ? cell_el[0] : el_i;
        head_pr_o = ge_vec[0] ? cell_pr[0] : pr_i;
      end
      MODE_DROP_HEAD, MODE_DROP_ELEMENT, MODE_DROP_MATCH: begin
        head_el_o = after_vec[0] ? cell_el[1] : cell_el[0];
        head_pr_o = after_vec[0] ? cell_pr[1] : cell_pr[0];
      end
      default: begin
        head_el_o = cell_el[0];
        head_pr_o = cell_pr[0];
      end
    endcase
  end

  // Read the entry at the cursor through an and-or tree
  always_comb begin
    item_el_o = '0;
    item_pr_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      item_el_o = item_el_o | (cell_el[i] & {ELEMENT_WIDTH{cell_flags[i].at_cursor}});
      item_pr_o = item_pr_o | (cell_pr[i] & {PRIORITY_WIDTH{cell_flags[i].at_cursor}});
    end
  end

endmodule

`default_nettype wire

FILE: dv/sorted_priority_queue_core_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned CAP = DEF_CAPACITY;
  localparam int unsigned EW  = DEF_ELEMENT_WIDTH;
  localparam int unsigned PW  = DEF_PRIORITY_WIDTH;
  localparam int unsigned CW  = $clog2(DEF_CAPACITY + 1);

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned STALL_PCT    = 30;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    status_e         status;
    logic            found;
    logic            item_valid;
    logic [EW-1:0]   item_element;
    logic [PW-1:0]   item_priority;
    logic [CW-1:0]   entry_count;
    logic            head_valid;
    logic [EW-1:0]   head_element;
    logic [PW-1:0]   head_priority;
  } queue_result_t;

  typedef struct packed {
    cmd_e            command;
    logic [EW-1:0]   element;
    logic [PW-1:0]   priority_req;
    logic [PW-1:0]   match_priority;
    logic            typed;
    queue_result_t   result;
  } stim_row_t;

  typedef struct {
    int unsigned     id;
    cmd_e            command;
    queue_result_t   result;
  } awaited_t;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } traffic_e;

  localparam queue_result_t EMPTY_OK    = '0;
  localparam queue_result_t UNCHECKED   = '0;
  localparam queue_result_t EMPTY_MISS  = '{STATUS_NOT_FOUND, 1'b0, 1'b0, '0, '0, '0,
                                            1'b0, '0, '0};
  localparam queue_result_t ONE_TOP     = '{STATUS_OK, 1'b0, 1'b0, '0, '0, 7'd1,
                                            1'b1, 16'hFFFF, 16'hFFFF};
  localparam queue_result_t TWO_TOP     = '{STATUS_OK, 1'b0, 1'b0, '0, '0, 7'd2,
                                            1'b1, 16'hFFFF, 16'hFFFF};

  localparam int unsigned N_DIRECTED = 28;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_REMOVE_HEAD,     16'h0000, 16'h0000, 16'h0000, 1'b1, EMPTY_OK},
    '{CMD_FIRST,           16'h0000, 16'h0000, 16'h0000, 1'b1, EMPTY_OK},
    '{CMD_NEXT,            16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, EMPTY_OK},
    '{CMD_CONTAINS,        16'h0000, 16'h0000, 16'h0000, 1'b1, EMPTY_OK},
    '{CMD_REMOVE_ELEMENT,  16'h5555, 16'hAAAA, 16'h5555, 1'b1, EMPTY_MISS},
    '{CMD_CHANGE_PRIORITY, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, EMPTY_MISS},
    '{CMD_INSERT,          16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, ONE_TOP},
    '{CMD_INSERT,          16'h0000, 16'h0000, 16'hFFFF, 1'b1, TWO_TOP},
    '{CMD_INSERT,          16'h1234, 16'h8000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_INSERT,          16'h4321, 16'h8000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_INSERT,          16'hAAAA, 16'h5555, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_FIRST,           16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_CONTAINS,        16'h1234, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_FIRST,           16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_INSERT,          16'h5555, 16'hAAAA, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_CHANGE_PRIORITY, 16'h1234, 16'h8000, 16'h8000, 1'b0, UNCHECKED},
    '{CMD_CHANGE_PRIORITY, 16'h4321, 16'h0001, 16'h0007, 1'b0, UNCHECKED},
    '{CMD_CHANGE_PRIORITY, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_REMOVE_ELEMENT,  16'hFFFF, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_REMOVE_HEAD,     16'h0000, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_CLEAR,           16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, EMPTY_OK},
    '{CMD_NEXT,            16'h0000, 16'h0000, 16'h0000, 1'b1, EMPTY_OK}
  };

  logic clk;
  logic rst_n;
  bit   stall_en;

  spq_cmd_if #(.ELEMENT_WIDTH(EW), .PRIORITY_WIDTH(PW)) cmd_bus ();
  spq_rsp_if #(.ELEMENT_WIDTH(EW), .PRIORITY_WIDTH(PW), .COUNT_WIDTH(CW)) rsp_bus ();

  sorted_priority_queue_core #(
    .CAPACITY      (CAP),
    .ELEMENT_WIDTH (EW),
    .PRIORITY_WIDTH(PW)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow copy of the sorted store and the iteration cursor
  logic [EW-1:0] shadow_el [CAP];
  logic [PW-1:0] shadow_pr [CAP];
  int unsigned   shadow_count;
  int unsigned   walk_pos;
  bit            walk_on;

  awaited_t      awaited_results[$];
  int unsigned   sent_total;
  int unsigned   checked_total;
  int unsigned   error_total;
  int unsigned   full_refusals;
  int unsigned   cmd_hits [8];
  int unsigned   quiet_cycles;

  // Free-running clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned locate(logic [EW-1:0] el, bit by_prio, logic [PW-1:0] pr);
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_el[i] == el && (!by_prio || shadow_pr[i] == pr)) return i;
    end
    return shadow_count;
  endfunction

  // Insert behind every entry of equal or higher priority; refuse when full
  function automatic bit put_sorted(logic [EW-1:0] el, logic [PW-1:0] pr);
    int unsigned pos;
    if (shadow_count >= CAP) return 1'b0;
    pos = 0;
    while (pos < shadow_count && shadow_pr[pos] >= pr) pos++;
    for (int unsigned i = shadow_count; i > pos; i--) begin
      shadow_el[i] = shadow_el[i-1];
      shadow_pr[i] = shadow_pr[i-1];
    end
    shadow_el[pos] = el;
    shadow_pr[pos] = pr;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
      shadow_el[i] = shadow_el[i+1];
      shadow_pr[i] = shadow_pr[i+1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow store and return the response it owes
  function automatic queue_result_t predict_queue(cmd_e c, logic [EW-1:0] el,
                                                  logic [PW-1:0] pr, logic [PW-1:0] op);
    queue_result_t r;
    int unsigned   pos;
    r = '0;
    r.status = STATUS_OK;
    case (c)
      CMD_INSERT: begin
        walk_on = 1'b0;
        if (!put_sorted(el, pr)) r.status = STATUS_FULL;
      end
      CMD_REMOVE_HEAD: begin
        walk_on = 1'b0;
        if (shadow_count > 0) drop_at(0);
      end
      CMD_REMOVE_ELEMENT: begin
        walk_on = 1'b0;
        pos = locate(el, 1'b0, '0);
        if (pos < shadow_count) drop_at(pos);
        else r.status = STATUS_NOT_FOUND;
      end
      CMD_CHANGE_PRIORITY: begin
        walk_on = 1'b0;
        pos = locate(el, 1'b1, op);
        if (pos >= shadow_count) begin
          r.status = STATUS_NOT_FOUND;
        end else if (!put_sorted(el, pr)) begin
          r.status = STATUS_FULL;
        end else begin
          pos = locate(el, 1'b1, op);
          if (pos < shadow_count) drop_at(pos);
        end
      end
      CMD_CONTAINS: begin
        r.found = (locate(el, 1'b0, '0) < shadow_count);
      end
      CMD_FIRST: begin
        walk_pos = 0;
        walk_on  = (shadow_count > 0);
      end
      CMD_NEXT: begin
        if (walk_on && walk_pos + 1 < shadow_count) walk_pos++;
        else walk_on = 1'b0;
      end
      default: begin
        shadow_count = 0;
        walk_on      = 1'b0;
      end
    endcase
    if ((c == CMD_FIRST || c == CMD_NEXT) && walk_on && walk_pos < shadow_count) begin
      r.item_valid    = 1'b1;
      r.item_element  = shadow_el[walk_pos];
      r.item_priority = shadow_pr[walk_pos];
    end
    r.entry_count = CW'(shadow_count);
    r.head_valid  = (shadow_count > 0);
    if (shadow_count > 0) begin
      r.head_element  = shadow_el[0];
      r.head_priority = shadow_pr[0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_total++;
  endtask

  task automatic check_field(awaited_t w, string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("#%0d %s %s got %0h expected %0h",
                                w.id, w.command.name(), name, got, want));
  endtask

  // Send one command; hold it until the transfer, then record its response
  task automatic issue(cmd_e c, logic [EW-1:0] el, logic [PW-1:0] pr, logic [PW-1:0] op,
                       bit typed, queue_result_t typed_res);
    awaited_t w;
    while (stall_en && $urandom_range(99) < STALL_PCT) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.command        <= c;
    cmd_bus.element        <= el;
    cmd_bus.priority_req   <= pr;
    cmd_bus.match_priority <= op;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    w.id      = sent_total;
    w.command = c;
    w.result  = predict_queue(c, el, pr, op);
    if (w.result.status == STATUS_FULL) full_refusals++;
    if (typed) w.result = typed_res;
    awaited_results.push_back(w);
    cmd_hits[int'(c)]++;
    sent_total++;
  endtask

  function automatic logic [PW-1:0] rand_priority();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 6) return PW'($urandom_range(7));
    return PW'($urandom());
  endfunction

  // Values already held in three of ten draws, so finds and removals can hit
  function automatic logic [EW-1:0] rand_element();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 5) return EW'($urandom_range(15));
    if (roll < 7 || shadow_count == 0) return EW'($urandom());
    return shadow_el[$urandom_range(shadow_count - 1)];
  endfunction

  function automatic cmd_e pick_cmd(traffic_e mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      MIX_FILL: begin
        if (roll < 85) return CMD_INSERT;
        if (roll < 93) return CMD_CHANGE_PRIORITY;
        if (roll < 97) return CMD_CONTAINS;
        return CMD_FIRST;
      end
      MIX_DRAIN: begin
        if (roll < 10) return CMD_INSERT;
        if (roll < 35) return CMD_REMOVE_HEAD;
        if (roll < 60) return CMD_REMOVE_ELEMENT;
        if (roll < 70) return CMD_CHANGE_PRIORITY;
        if (roll < 80) return CMD_CONTAINS;
        if (roll < 88) return CMD_FIRST;
        if (roll < 97) return CMD_NEXT;
        return CMD_CLEAR;
      end
      default: begin
        if (roll < 32) return CMD_INSERT;
        if (roll < 42) return CMD_REMOVE_HEAD;
        if (roll < 54) return CMD_REMOVE_ELEMENT;
        if (roll < 68) return CMD_CHANGE_PRIORITY;
        if (roll < 78) return CMD_CONTAINS;
        if (roll < 86) return CMD_FIRST;
        if (roll < 97) return CMD_NEXT;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  // Re-prioritize a held entry most of the time, a random pair otherwise
  task automatic send_change(bit force_hit);
    int unsigned   idx;
    logic [EW-1:0] el;
    logic [PW-1:0] op;
    logic [PW-1:0] pr;
    if (shadow_count > 0 && (force_hit || $urandom_range(3) != 0)) begin
      idx = $urandom_range(shadow_count - 1);
      el  = shadow_el[idx];
      op  = shadow_pr[idx];
      pr  = ($urandom_range(3) == 0) ? op : rand_priority();
    end else begin
      el = rand_element();
      op = rand_priority();
      pr = rand_priority();
    end
    issue(CMD_CHANGE_PRIORITY, el, pr, op, 1'b0, UNCHECKED);
  endtask

  task automatic random_item(traffic_e mode);
    cmd_e        c;
    int unsigned walk_len;
    c = pick_cmd(mode);
    case (c)
      CMD_CHANGE_PRIORITY: send_change(1'b0);
      CMD_FIRST: begin
        // Walk the list, sometimes past its end
        issue(CMD_FIRST, EW'($urandom()), PW'($urandom()), PW'($urandom()), 1'b0, UNCHECKED);
        walk_len = $urandom_range(shadow_count + 2);
        repeat (walk_len)
          issue(CMD_NEXT, EW'($urandom()), PW'($urandom()), PW'($urandom()), 1'b0, UNCHECKED);
      end
      default: issue(c, rand_element(), rand_priority(), PW'($urandom()), 1'b0, UNCHECKED);
    endcase
  endtask

  // Stimulus: reset, directed table, then random traffic in segments
  initial begin
    int unsigned random_start;
    int unsigned segment;
    int unsigned seg_start;
    cmd_bus.valid          = 1'b0;
    cmd_bus.command        = CMD_INSERT;
    cmd_bus.element        = '0;
    cmd_bus.priority_req   = '0;
    cmd_bus.match_priority = '0;
    rsp_bus.ready          = 1'b0;
    rst_n                  = 1'b0;
    stall_en               = 1'b1;
    shadow_count           = 0;
    walk_pos               = 0;
    walk_on                = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < N_DIRECTED; i++)
      issue(DIRECTED[i].command, DIRECTED[i].element, DIRECTED[i].priority_req,
            DIRECTED[i].match_priority, DIRECTED[i].typed, DIRECTED[i].result);

    random_start = sent_total;
    segment      = 0;
    while (sent_total - random_start < RANDOM_ITEMS) begin
      seg_start = sent_total;
      stall_en  = (segment % 4 != 1);
      case (segment % 4)
        0: begin
          // Fill to capacity, then hammer the full store
          while (shadow_count < CAP && sent_total - seg_start < 300 &&
                 sent_total - random_start < RANDOM_ITEMS) random_item(MIX_FILL);
          repeat (4) begin
            issue(CMD_INSERT, rand_element(), rand_priority(), PW'($urandom()), 1'b0, UNCHECKED);
            send_change(1'b1);
          end
        end
        2: begin
          while (sent_total - seg_start < 60 && sent_total - random_start < RANDOM_ITEMS)
            random_item(MIX_DRAIN);
        end
        default: begin
          while (sent_total - seg_start < 80 && sent_total - random_start < RANDOM_ITEMS)
            random_item(MIX_BALANCED);
        end
      endcase
      segment++;
    end
    cmd_bus.valid <= 1'b0;
    stall_en = 1'b1;

    // Drain outstanding responses, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands, %0d responses checked, %0d full refusals.",
             sent_total, checked_total, full_refusals);
    $display("Per command: ins %0d rmh %0d rme %0d chg %0d has %0d fst %0d nxt %0d clr %0d",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3],
             cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
    if (error_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Response side: random back-pressure and field-by-field compare
  always @(posedge clk) begin
    awaited_t w;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("response transfer with nothing outstanding");
      end else begin
        w = awaited_results.pop_front();
        check_field(w, "status",        rsp_bus.status,        w.result.status);
        check_field(w, "found",         rsp_bus.found,         w.result.found);
        check_field(w, "item_valid",    rsp_bus.item_valid,    w.result.item_valid);
        check_field(w, "item_element",  rsp_bus.item_element,  w.result.item_element);
        check_field(w, "item_priority", rsp_bus.item_priority, w.result.item_priority);
        check_field(w, "entry_count",   rsp_bus.entry_count,   w.result.entry_count);
        check_field(w, "head_valid",    rsp_bus.head_valid,    w.result.head_valid);
        check_field(w, "head_element",  rsp_bus.head_element,  w.result.head_element);
        check_field(w, "head_priority", rsp_bus.head_priority, w.result.head_priority);
        checked_total++;
      end
    end
    rsp_bus.ready <= stall_en ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d responses outstanding",
                 $time, QUIET_LIMIT, awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

FILE: sorted_priority_queue_core.f
rtl/spq_pkg.sv
rtl/spq_cmd_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/spq_chain.sv
rtl/sorted_priority_queue_core.sv
dv/sorted_priority_queue_core_test.sv
